FILE: sv/bse_pkg.sv
// Shared types, codes and constants for the BASIC statement executor.
// Used by the top level, the shared arithmetic unit and the port checker; no dependencies.
package bse_pkg;

  localparam int NUM_VARIABLES_DEF = 26;
  localparam int DATA_W            = 32;
  localparam int IDX_W             = 5;
  localparam int TARGET_W          = 31;

  // Statement kinds.
  localparam logic [1:0] CMD_LET   = 2'd0;
  localparam logic [1:0] CMD_IF    = 2'd1;
  localparam logic [1:0] CMD_PRINT = 2'd2;

  // Assign functions.
  localparam logic [2:0] FN_COPY = 3'd0;
  localparam logic [2:0] FN_ADD  = 3'd1;
  localparam logic [2:0] FN_SUB  = 3'd2;
  localparam logic [2:0] FN_MUL  = 3'd3;
  localparam logic [2:0] FN_DIV  = 3'd4;

  // Comparison functions.
  localparam logic [2:0] CMP_EQ = 3'd0;
  localparam logic [2:0] CMP_GT = 3'd1;
  localparam logic [2:0] CMP_LT = 3'd2;
  localparam logic [2:0] CMP_NE = 3'd3;
  localparam logic [2:0] CMP_LE = 3'd4;
  localparam logic [2:0] CMP_GE = 3'd5;

  // Result kinds.
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_JUMP  = 2'd1;
  localparam logic [1:0] KIND_PRINT = 2'd2;

  typedef struct packed {
    logic        [1:0]          cmd;
    logic        [2:0]          func;
    logic        [IDX_W-1:0]    dest;
    logic                       a_is_var;
    logic        [IDX_W-1:0]    a_reg;
    logic signed [DATA_W-1:0]   a_lit;
    logic                       b_is_var;
    logic        [IDX_W-1:0]    b_reg;
    logic signed [DATA_W-1:0]   b_lit;
    logic        [TARGET_W-1:0] target;
    logic                       newline;
  } bse_in_t;

  typedef struct packed {
    logic        [1:0]          kind;
    logic signed [DATA_W-1:0]   value;
    logic        [TARGET_W-1:0] jump_to;
    logic                       line_break;
    logic                       div_error;
  } bse_out_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] value;
    logic              neg;
    logic              zero;
  } alu_rsp_t;

  typedef enum logic [2:0] {
    AU_IDLE,
    AU_ADDSUB,
    AU_NEG_A,
    AU_NEG_B,
    AU_MUL,
    AU_DIV,
    AU_NEG_Q,
    AU_DONE
  } alu_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_DECIDE,
    ST_WAIT_ALU,
    ST_FINISH
  } exec_state_t;

endpackage

FILE: sv/bse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bse_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 26,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/bse_alu.sv
// Shared iterative arithmetic unit: add, subtract/compare, shift-add multiply and
// restoring divide, all on one 34-bit adder. Depends on bse_pkg.
module bse_alu import bse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  alu_state_t        st_r, st_nxt;
  alu_op_t           op_r;
  logic [DATA_W-1:0] x_r, y_r, z_r;
  logic [4:0]        cnt_r;
  logic              sign_r, neg_r, zero_r;

  logic [DATA_W:0]   add_x, add_y;
  logic              add_sub;
  logic [DATA_W+1:0] add_res;
  logic              last_step;

  assign last_step = (cnt_r == 5'd31);
  assign add_res   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} +
                     (DATA_W+2)'(add_sub);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      AU_IDLE: begin
        if (req.start) begin
          case (req.op)
            ALU_MUL: st_nxt = AU_MUL;
            ALU_DIV: st_nxt = AU_NEG_A;
            default: st_nxt = AU_ADDSUB;
          endcase
        end
      end
      AU_ADDSUB: st_nxt = AU_DONE;
      AU_NEG_A:  st_nxt = AU_NEG_B;
      AU_NEG_B:  st_nxt = AU_DIV;
      AU_MUL: begin
        if (last_step) st_nxt = AU_DONE;
      end
      AU_DIV: begin
        if (last_step) st_nxt = AU_NEG_Q;
      end
      AU_NEG_Q:  st_nxt = AU_DONE;
      AU_DONE:   st_nxt = AU_IDLE;
      default:   st_nxt = AU_IDLE;
    endcase
  end

  // Adder operand selection for each step.
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (st_r)
      AU_ADDSUB: begin
        add_x   = {x_r[DATA_W-1], x_r};
        add_y   = {y_r[DATA_W-1], y_r};
        add_sub = (op_r != ALU_ADD);
      end
      AU_NEG_A: begin
        add_y   = {1'b0, x_r};
        add_sub = 1'b1;
      end
      AU_NEG_B: begin
        add_y   = {1'b0, y_r};
        add_sub = 1'b1;
      end
      AU_MUL: begin
        add_x = {1'b0, x_r};
        add_y = {1'b0, y_r};
      end
      AU_DIV: begin
        add_x   = {x_r, z_r[DATA_W-1]};
        add_y   = {1'b0, y_r};
        add_sub = 1'b1;
      end
      AU_NEG_Q: begin
        add_y   = {1'b0, z_r};
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign rsp.done  = (st_r == AU_DONE);
  assign rsp.value = x_r;
  assign rsp.neg   = neg_r;
  assign rsp.zero  = zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= AU_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      AU_IDLE: begin
        if (req.start) begin
          op_r   <= req.op;
          sign_r <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
          cnt_r  <= '0;
          if (req.op == ALU_MUL) begin
            x_r <= '0;
            y_r <= req.a;
            z_r <= req.b;
          end else begin
            x_r <= req.a;
            y_r <= req.b;
            z_r <= '0;
          end
        end
      end
      AU_ADDSUB: begin
        x_r    <= add_res[DATA_W-1:0];
        neg_r  <= add_res[DATA_W];
        zero_r <= (add_res[DATA_W:0] == '0);
      end
      AU_NEG_A: begin
        if (x_r[DATA_W-1]) x_r <= add_res[DATA_W-1:0];
      end
      AU_NEG_B: begin
        if (y_r[DATA_W-1]) y_r <= add_res[DATA_W-1:0];
        z_r   <= x_r;
        x_r   <= '0;
        cnt_r <= '0;
      end
      AU_MUL: begin
        if (z_r[0]) x_r <= add_res[DATA_W-1:0];
        y_r   <= {y_r[DATA_W-2:0], 1'b0};
        z_r   <= {1'b0, z_r[DATA_W-1:1]};
        cnt_r <= cnt_r + 5'd1;
      end
      AU_DIV: begin
        // The top adder bit is set when the trial subtraction does not borrow.
        if (add_res[DATA_W+1]) begin
          x_r <= add_res[DATA_W-1:0];
          z_r <= {z_r[DATA_W-2:0], 1'b1};
        end else begin
          x_r <= {x_r[DATA_W-2:0], z_r[DATA_W-1]};
          z_r <= {z_r[DATA_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
      end
      AU_NEG_Q: begin
        x_r <= sign_r ? add_res[DATA_W-1:0] : z_r;
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/basic_statement_executor.sv
// BASIC statement executor, top level. Depends on bse_pkg, bse_ram (variable store)
// and bse_alu (shared arithmetic unit).
//
// The block runs one pre-decoded BASIC statement per input item against a store of
// NUM_VARIABLES signed 32-bit variables, which read as zero after reset. Each item
// produces exactly one result item: a jump target when an IF test holds, a value and
// line-break flag for PRINT, and otherwise an empty result that carries the
// division-by-zero flag. The block works on one item at a time and drops in_ready
// from acceptance until the result has been handed to the output register. A copy,
// PRINT, divide by zero, unknown statement or unknown comparison bypasses the shared
// unit; an add, subtract or IF uses it for a single adder step. A multiply or divide
// runs on the shared adder, which retires one multiplier or quotient bit per cycle
// over 32 steps, plus the operand and quotient sign steps of a divide. The two
// operands are read from the single read port of the variable store in consecutive
// cycles. The output register lets a finished result wait for out_ready while the
// block goes back to accepting the next item.
module basic_statement_executor import bse_pkg::*; #(
  parameter int NUM_VARIABLES = NUM_VARIABLES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bse_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bse_out_t out_data
);

  localparam int AW = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;

  // Maps a variable index field onto a store address.
  function automatic logic [AW-1:0] idx_addr(input logic [IDX_W-1:0] idx);
    logic [AW+IDX_W-1:0] ext;
    ext = {{AW{1'b0}}, idx};
    return ext[AW-1:0];
  endfunction

  // True when the index names a variable that exists.
  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    return (int'(idx) < NUM_VARIABLES);
  endfunction

  exec_state_t        st_r, st_nxt;
  bse_in_t            item_r;
  logic [DATA_W-1:0]  a_r, b_r;
  bse_out_t           res_r, res_nxt;
  bse_out_t           out_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  logic [NUM_VARIABLES-1:0] vld_r;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [DATA_W-1:0]  ram_wdata, ram_rdata;

  logic [AW-1:0]      a_addr, b_addr;
  logic [DATA_W-1:0]  a_opnd, b_opnd;
  logic               dest_ok;

  logic               need_alu;
  alu_op_t            alu_op;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  logic               hold;

  // Variable store. Entries that were never written read as zero through vld_r.
  bse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_VARIABLES)
  ) u_vars (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bse_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign a_addr  = idx_addr(item_r.a_reg);
  assign b_addr  = idx_addr(item_r.b_reg);
  assign dest_ok = idx_ok(item_r.dest);

  // The first operand address goes to the store as the item is accepted; the
  // second one goes out in ST_RD_A, while the first read data is captured.
  assign ram_raddr = (st_r == ST_IDLE) ? idx_addr(in_data.a_reg) : b_addr;

  // A variable operand that is out of range or never written reads as zero.
  always_comb begin
    if (!item_r.a_is_var) begin
      a_opnd = item_r.a_lit;
    end else if (idx_ok(item_r.a_reg) && vld_r[a_addr]) begin
      a_opnd = ram_rdata;
    end else begin
      a_opnd = '0;
    end
    if (!item_r.b_is_var) begin
      b_opnd = item_r.b_lit;
    end else if (idx_ok(item_r.b_reg) && vld_r[b_addr]) begin
      b_opnd = ram_rdata;
    end else begin
      b_opnd = '0;
    end
  end

  // Decides which statements go through the shared unit. A compare is a
  // subtraction whose sign and zero flags pick the outcome. A divide by zero
  // never starts the unit.
  always_comb begin
    need_alu = 1'b0;
    alu_op   = ALU_SUB;
    case (item_r.cmd)
      CMD_LET: begin
        case (item_r.func)
          FN_ADD: begin
            need_alu = 1'b1;
            alu_op   = ALU_ADD;
          end
          FN_SUB: begin
            need_alu = 1'b1;
            alu_op   = ALU_SUB;
          end
          FN_MUL: begin
            need_alu = 1'b1;
            alu_op   = ALU_MUL;
          end
          FN_DIV: begin
            need_alu = (b_r != '0);
            alu_op   = ALU_DIV;
          end
          default: ;
        endcase
      end
      CMD_IF: begin
        need_alu = (item_r.func inside {[CMP_EQ:CMP_GE]});
        alu_op   = ALU_SUB;
      end
      default: ;
    endcase
  end

  // Outcome of an IF test from the flags of a minus b.
  always_comb begin
    case (item_r.func)
      CMP_EQ:  hold = alu_rsp.zero;
      CMP_GT:  hold = !alu_rsp.neg && !alu_rsp.zero;
      CMP_LT:  hold = alu_rsp.neg;
      CMP_NE:  hold = !alu_rsp.zero;
      CMP_LE:  hold = alu_rsp.neg || alu_rsp.zero;
      CMP_GE:  hold = !alu_rsp.neg;
      default: hold = 1'b0;
    endcase
  end

  assign out_load = (st_r == ST_FINISH) && (!out_valid_r || out_ready);

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_valid) st_nxt = ST_RD_A;
      end
      ST_RD_A:   st_nxt = ST_RD_B;
      ST_RD_B:   st_nxt = ST_DECIDE;
      ST_DECIDE: st_nxt = need_alu ? ST_WAIT_ALU : ST_FINISH;
      ST_WAIT_ALU: begin
        if (alu_rsp.done) st_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) st_nxt = ST_IDLE;
      end
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: store writes, unit start and the staged result.
  always_comb begin
    in_ready      = (st_r == ST_IDLE);
    ram_we        = 1'b0;
    ram_waddr     = idx_addr(item_r.dest);
    ram_wdata     = a_r;
    res_nxt       = res_r;
    alu_req.start = 1'b0;
    alu_req.op    = alu_op;
    alu_req.a     = a_r;
    alu_req.b     = b_r;
    case (st_r)
      ST_DECIDE: begin
        res_nxt       = '0;
        alu_req.start = need_alu;
        case (item_r.cmd)
          CMD_LET: begin
            if (item_r.func == FN_COPY) begin
              ram_we = dest_ok;
            end else if (item_r.func == FN_DIV && b_r == '0) begin
              res_nxt.div_error = 1'b1;
            end
          end
          CMD_PRINT: begin
            res_nxt.kind       = KIND_PRINT;
            res_nxt.value      = a_r;
            res_nxt.line_break = item_r.newline;
          end
          default: ;
        endcase
      end
      ST_WAIT_ALU: begin
        if (alu_rsp.done) begin
          res_nxt = '0;
          if (item_r.cmd == CMD_LET) begin
            ram_we    = dest_ok;
            ram_wdata = alu_rsp.value;
          end else if (hold) begin
            res_nxt.kind    = KIND_JUMP;
            res_nxt.jump_to = item_r.target;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) vld_r[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && in_valid) item_r <= in_data;
    if (st_r == ST_RD_A) a_r <= a_opnd;
    if (st_r == ST_RD_B) b_r <= b_opnd;
    res_r <= res_nxt;
    if (out_load) out_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: sv/bse_checker.sv
// Port-level checker for the BASIC statement executor, bound to the top level.
// Depends on bse_pkg.
module bse_checker import bse_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input bse_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input bse_out_t out_data
);

  // One item at a time: accepting an item closes the input for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after an item was accepted");

  // A waiting result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result item changed or vanished while stalled");

  // Only a print carries a value or a line break.
  a_print_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.kind == KIND_PRINT ||
                   (out_data.value == '0 && out_data.line_break == 1'b0)))
    else $error("value or line break set on a non-print result");

  // A divide by zero reports nothing else.
  a_div_error_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.div_error) |-> (out_data.kind == KIND_NONE &&
                                           out_data.jump_to == '0))
    else $error("division error combined with a jump or print result");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind basic_statement_executor bse_checker u_bse_checker (.*);
